// ===== design/distinct_prime_factor_count_core_macros.svh =====
// assertion macros for the distinct prime factor counter
`ifndef DISTINCT_PRIME_FACTOR_COUNT_CORE_MACROS_SVH
`define DISTINCT_PRIME_FACTOR_COUNT_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DPFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define DPFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dpfc_pkg.sv =====
// package with shared types and constants of the distinct prime factor counter
`timescale 1ns / 1ps

package dpfc_pkg;

   localparam int PRIME_COUNT_WIDTH = 4;
   localparam int FIRST_ODD_DIVISOR = 3;
   localparam int DIVISOR_STEP      = 2;
   localparam int SMALLEST_PRIME    = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STRIP,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

endpackage

// ===== design/dpfc_if.sv =====
// request and response channel interfaces of the distinct prime factor counter
`timescale 1ns / 1ps

interface dpfc_req_if #(
   parameter int VALUE_WIDTH = 31
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface dpfc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [dpfc_pkg::PRIME_COUNT_WIDTH-1:0] prime_count;
   logic                                   invalid;

   modport source (output valid, output prime_count, output invalid, input ready);
   modport sink   (input valid, input prime_count, input invalid, output ready);
endinterface

// ===== design/distinct_prime_factor_count_core.sv =====
// z trailing zero bits are stripped first, then t trial divisions run one at a time
// on the one shared divider; t is about sqrt(n)/2 in the worst case (large prime)
// a new item is taken while the result waits, but not before the current item is through
// zero input returns the invalid flag
// synchronous active-high reset clears the sequencer and the output valid; no memories
`timescale 1ns / 1ps

module distinct_prime_factor_count_core #(
   parameter int VALUE_WIDTH = 31
) (
   input  logic       clock,
   input  logic       reset,
   dpfc_req_if.sink   req_ch,
   dpfc_rsp_if.source rsp_ch
);

   localparam int CW = dpfc_pkg::PRIME_COUNT_WIDTH;

   dpfc_pkg::state_type    state_ff, state_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   inner_ff, inner_in;
   logic                   zero_ff, zero_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;
   logic                   rsp_invalid_ff, rsp_invalid_in;

   logic                   div_start;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quo;
   logic [VALUE_WIDTH-1:0] div_rem;
   logic                   load;
   logic                   accept;

   dpfc_div #(.WIDTH(VALUE_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rem_ff),
      .divisor   (dsr_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign accept = req_ch.valid && (state_ff == dpfc_pkg::ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      rem_in         = rem_ff;
      dsr_in         = dsr_ff;
      cnt_in         = cnt_ff;
      inner_in       = inner_ff;
      zero_in        = zero_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_invalid_in = rsp_invalid_ff;
      div_start      = 1'b0;
      load           = 1'b0;

      case (state_ff)
         dpfc_pkg::ST_IDLE: begin
            if (accept) begin
               rem_in   = req_ch.value;
               cnt_in   = '0;
               inner_in = 1'b0;
               zero_in  = (req_ch.value == '0);
               state_in = (req_ch.value == '0) ? dpfc_pkg::ST_FINISH : dpfc_pkg::ST_STRIP;
            end
         end
         dpfc_pkg::ST_STRIP: begin
            // remove every factor two
            if (!rem_ff[0]) begin
               rem_in = rem_ff >> 1;
               cnt_in = CW'(1);
            end else begin
               dsr_in   = VALUE_WIDTH'(dpfc_pkg::FIRST_ODD_DIVISOR);
               state_in = dpfc_pkg::ST_DIV_GO;
            end
         end
         dpfc_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = dpfc_pkg::ST_DIV_WAIT;
         end
         dpfc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = dpfc_pkg::ST_DIV_GO;
               if (inner_ff) begin
                  if (div_rem == '0) begin
                     rem_in = div_quo;
                  end else begin
                     inner_in = 1'b0;
                     dsr_in   = dsr_ff + VALUE_WIDTH'(dpfc_pkg::DIVISOR_STEP);
                  end
               end else if (dsr_ff > div_quo) begin
                  // divisor squared exceeds remainder
                  state_in = dpfc_pkg::ST_FINISH;
               end else if (div_rem == '0) begin
                  cnt_in   = cnt_ff + CW'(1);
                  rem_in   = div_quo;
                  inner_in = 1'b1;
               end else begin
                  dsr_in = dsr_ff + VALUE_WIDTH'(dpfc_pkg::DIVISOR_STEP);
               end
            end
         end
         dpfc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load           = 1'b1;
               rsp_invalid_in = zero_ff;
               rsp_count_in   = (rem_ff >= VALUE_WIDTH'(dpfc_pkg::SMALLEST_PRIME))
                                ? cnt_ff + CW'(1) : cnt_ff;
               state_in       = dpfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dpfc_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dpfc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      dsr_ff         <= dsr_in;
      cnt_ff         <= cnt_in;
      inner_ff       <= inner_in;
      zero_ff        <= zero_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign req_ch.ready       = (state_ff == dpfc_pkg::ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.prime_count = rsp_count_ff;
   assign rsp_ch.invalid     = rsp_invalid_ff;

endmodule

// ===== design/dpfc_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module dpfc_div #(
   parameter int WIDTH = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH:0]   part_ff, part_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;
   logic             fits;

   always_comb begin
      shifted = {part_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      diff    = shifted - {1'b0, dsr_ff};

      part_in = part_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         part_in = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         part_in = fits ? diff : shifted;
         quo_in  = {quo_ff[WIDTH-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = part_ff[WIDTH-1:0];

endmodule

// ===== design/dpfc_chk.sv =====
// port checker for the distinct prime factor counter, bound to the top level
`timescale 1ns / 1ps
`include "distinct_prime_factor_count_core_macros.svh"

module dpfc_chk (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [dpfc_pkg::PRIME_COUNT_WIDTH-1:0] rsp_prime_count,
   input logic                                   rsp_invalid
);

   `DPFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `DPFC_ASSERT_SAME(a_invalid_zero, clock, reset, rsp_valid && rsp_invalid, rsp_prime_count == '0, "invalid item with nonzero count")
   `DPFC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")

endmodule

bind distinct_prime_factor_count_core dpfc_chk u_dpfc_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_prime_count (rsp_ch.prime_count),
   .rsp_invalid     (rsp_ch.invalid)
);

// ===== sim/tb_distinct_prime_factor_count_core.sv =====
// testbench: checks the distinct prime factor counter against its own predictor of each item
`timescale 1ns / 1ps

module tb_distinct_prime_factor_count_core;

   localparam int VALUE_WIDTH = 31;
   localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 1;
   localparam int RANDOM_ITEMS = 100;
   localparam int unsigned MAX_RANDOM_DIVISIONS = 300;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int HOLDOFF_AFTER = 4;
   localparam int REPORT_LIMIT = 10;
   localparam int DRAIN_CYCLES = 40;
   localparam int CW = dpfc_pkg::PRIME_COUNT_WIDTH;

   typedef struct {
      logic [VALUE_WIDTH-1:0] value;
      logic [CW-1:0]          prime_count;
      logic                   invalid;
   } factor_result_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_MOSTLY,
      RX_RARELY
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   dpfc_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_if ();
   dpfc_rsp_if rsp_if ();

   distinct_prime_factor_count_core #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #4 clock = ~clock;

   logic [VALUE_WIDTH-1:0] pending_values[$];
   factor_result_type      expected_factors[$];

   logic item_taken;
   int   items_accepted = 0;
   int   results_checked = 0;
   int   mismatch_count = 0;
   int   directed_count = 0;
   int   random_count = 0;
   int   zero_inputs = 0;
   int   top_count_seen = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   holdoff_left = 0;
   bit   holdoff_done = 1'b0;
   int   pattern_left = 0;
   rx_mode_type pattern_mode = RX_ALWAYS;

   int unsigned small_primes [0:15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                                        47, 53};

   logic [VALUE_WIDTH-1:0] directed_values [0:19] = '{
      31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd8, 31'd9, 31'd25, 31'd49, 31'd97, 31'd360,
      31'd994009, 31'd1000003, 31'd223092870, 31'h4000_0000, 31'h6000_0000, 31'h5555_5555,
      31'h7FFF_FFF0, 31'h7FFF_FFFE, 31'h7FFF_FFFF
   };

   // trial division count of distinct primes, divisions tallies the divider work
   function automatic factor_result_type predict_factors(input logic [VALUE_WIDTH-1:0] value,
                                                         output int unsigned divisions);
      factor_result_type result;
      longint unsigned   rem;
      longint unsigned   divisor;
      int unsigned       count;
      result.value = value;
      result.invalid = (value == '0);
      rem = 64'(value);
      count = 0;
      divisions = 0;
      if (rem >= dpfc_pkg::SMALLEST_PRIME) begin
         if (rem[0] == 1'b0) begin
            count++;
            while (rem[0] == 1'b0) rem = rem >> 1;
         end
         for (divisor = dpfc_pkg::FIRST_ODD_DIVISOR; divisor * divisor <= rem;
              divisor += dpfc_pkg::DIVISOR_STEP) begin
            divisions++;
            if (rem % divisor == 0) begin
               count++;
               while (rem % divisor == 0) begin
                  rem = rem / divisor;
                  divisions++;
               end
            end
         end
         if (rem >= dpfc_pkg::SMALLEST_PRIME) count++;
      end
      result.prime_count = count[CW-1:0];
      return result;
   endfunction

   // sender: bursts of items separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.value <= '0;
      end else if (!req_if.valid || item_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_values.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.value <= pending_values.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 6);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver: one long hold-off early on, otherwise a changing stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_if.ready <= 1'b0;
      end else if (!holdoff_done && results_checked >= HOLDOFF_AFTER) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode = rx_mode_type'($urandom_range(0, 2));
            pattern_left = $urandom_range(8, 64);
         end
         pattern_left--;
         case (pattern_mode)
            RX_ALWAYS: rsp_if.ready <= 1'b1;
            RX_MOSTLY: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor: check results first, then predict for a newly taken item
   always @(posedge clock) begin
      factor_result_type predicted;
      factor_result_type oldest;
      int unsigned       divisions;
      item_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (expected_factors.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected item: count %0d invalid %0b", rsp_if.prime_count,
                           rsp_if.invalid);
            end else begin
               oldest = expected_factors.pop_front();
               if (rsp_if.prime_count !== oldest.prime_count ||
                   rsp_if.invalid !== oldest.invalid) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("value %0d: expected count %0d invalid %0b, %s %0d invalid %0b",
                              oldest.value, oldest.prime_count, oldest.invalid,
                              "got count", rsp_if.prime_count, rsp_if.invalid);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            predicted = predict_factors(req_if.value, divisions);
            expected_factors.push_back(predicted);
            items_accepted++;
            if (predicted.invalid) zero_inputs++;
            if (predicted.prime_count > top_count_seen) top_count_seen = predicted.prime_count;
         end
      end
   end

   initial begin
      logic [VALUE_WIDTH-1:0] candidate;
      longint unsigned        product;
      longint unsigned        limit;
      int unsigned            prime;
      int unsigned            divisions;
      factor_result_type      scratch;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      foreach (directed_values[i]) pending_values.push_back(directed_values[i]);
      directed_count = pending_values.size();
      while (random_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: candidate = VALUE_WIDTH'($urandom);
            4, 5, 6: begin
               product = 1;
               repeat ($urandom_range(1, 8)) begin
                  prime = small_primes[$urandom_range(0, 15)];
                  if (product * prime <= VALUE_MAX) product = product * prime;
               end
               if ($urandom_range(0, 1) == 1) begin
                  limit = VALUE_MAX / product;
                  if (limit > 65535) limit = 65535;
                  product = product * $urandom_range(1, 32'(limit));
               end
               candidate = product[VALUE_WIDTH-1:0];
            end
            7, 8:    candidate = VALUE_WIDTH'($urandom_range(0, 4095));
            default: candidate = VALUE_WIDTH'($urandom_range(0, 1));
         endcase
         // keep random items cheap so the run stays short
         scratch = predict_factors(candidate, divisions);
         if (divisions <= MAX_RANDOM_DIVISIONS) begin
            pending_values.push_back(candidate);
            random_count++;
         end
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (!(items_accepted == directed_count + random_count &&
               expected_factors.size() == 0))
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatch_count += expected_factors.size();
      $display("covered %0d items (%0d directed, %0d random), %0d results checked",
               items_accepted, directed_count, random_count, results_checked);
      $display("zero inputs %0d, largest count %0d, hold-off of %0d cycles, %0d failures",
               zero_inputs, top_count_seen, HOLDOFF_CYCLES, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/dpfc_pkg.sv
design/dpfc_if.sv
design/dpfc_div.sv
design/distinct_prime_factor_count_core.sv
design/dpfc_chk.sv
sim/tb_distinct_prime_factor_count_core.sv
